// ----- src/llx_pkg.sv -----
`timescale 1ns / 1ps
// Shared types, codes and keyword tables for the Lisp lexer stream block.
// Used by llx_step and lisp_lexer_stream_top; depends on nothing else.
package llx_pkg;

   localparam int MAX_TOKEN_LEN_DEF = 4095;
   localparam int NUM_KW = 17;
   localparam int KW_CHARS = 9;
   localparam logic [16:0] ALL_KW = 17'h1FFFF;

   typedef enum logic [2:0] {
      MODE_IDLE    = 3'd0,
      MODE_COMMENT = 3'd1,
      MODE_NUMBER  = 3'd2,
      MODE_SYMBOL  = 3'd3,
      MODE_STRING  = 3'd4,
      MODE_GT      = 3'd5,
      MODE_LT      = 3'd6
   } mode_type;

   typedef enum logic [1:0] {
      REC_CONTENT = 2'd0,
      REC_END     = 2'd1,
      REC_ERROR   = 2'd2,
      REC_EOT     = 2'd3
   } rec_kind_type;

   localparam logic [4:0] TK_LPAREN = 5'd0;
   localparam logic [4:0] TK_RPAREN = 5'd1;
   localparam logic [4:0] TK_NUMBER = 5'd2;
   localparam logic [4:0] TK_PLUS   = 5'd3;
   localparam logic [4:0] TK_MINUS  = 5'd4;
   localparam logic [4:0] TK_STAR   = 5'd5;
   localparam logic [4:0] TK_SLASH  = 5'd6;
   localparam logic [4:0] TK_STRING = 5'd7;
   localparam logic [4:0] TK_EQ     = 5'd8;
   localparam logic [4:0] TK_GT     = 5'd9;
   localparam logic [4:0] TK_GTE    = 5'd10;
   localparam logic [4:0] TK_LT     = 5'd11;
   localparam logic [4:0] TK_LTE    = 5'd12;
   localparam logic [4:0] TK_SYMBOL = 5'd13;
   localparam logic [4:0] TK_KW0    = 5'd14;

   localparam logic [7:0] CH_TAB    = 8'h09;
   localparam logic [7:0] CH_LF     = 8'h0A;
   localparam logic [7:0] CH_SPACE  = 8'h20;
   localparam logic [7:0] CH_QUOTE  = 8'h22;
   localparam logic [7:0] CH_LPAREN = 8'h28;
   localparam logic [7:0] CH_RPAREN = 8'h29;
   localparam logic [7:0] CH_STAR   = 8'h2A;
   localparam logic [7:0] CH_PLUS   = 8'h2B;
   localparam logic [7:0] CH_MINUS  = 8'h2D;
   localparam logic [7:0] CH_SLASH  = 8'h2F;
   localparam logic [7:0] CH_SEMI   = 8'h3B;
   localparam logic [7:0] CH_LT     = 8'h3C;
   localparam logic [7:0] CH_EQ     = 8'h3D;
   localparam logic [7:0] CH_GT     = 8'h3E;

   typedef struct packed {
      rec_kind_type kind;
      logic [4:0]   token_kind;
      logic [7:0]   content_byte;
      logic [11:0]  span_len;
   } rec_type;

   typedef struct packed {
      mode_type     mode;
      logic [11:0]  run_length;
      logic [16:0]  cands;
   } lex_state_type;

   typedef struct packed {
      rec_type [2:0] recs;
      logic [1:0]    count;
      lex_state_type next;
   } step_type;

   localparam lex_state_type LEX_RESET = '{mode: MODE_IDLE, run_length: 12'd0, cands: ALL_KW};

   // keyword text, first character in the top byte
   function automatic logic [71:0] kw_text(input logic [4:0] k);
      case (k)
         5'd0:    kw_text = "lambda   ";
         5'd1:    kw_text = "if       ";
         5'd2:    kw_text = "quote    ";
         5'd3:    kw_text = "nil      ";
         5'd4:    kw_text = "t        ";
         5'd5:    kw_text = "define   ";
         5'd6:    kw_text = "set!     ";
         5'd7:    kw_text = "loop     ";
         5'd8:    kw_text = "dotimes  ";
         5'd9:    kw_text = "print    ";
         5'd10:   kw_text = "println  ";
         5'd11:   kw_text = "str      ";
         5'd12:   kw_text = "length   ";
         5'd13:   kw_text = "bool?    ";
         5'd14:   kw_text = "now      ";
         5'd15:   kw_text = "sleep    ";
         5'd16:   kw_text = "time-diff";
         default: kw_text = '0;
      endcase
   endfunction

   function automatic logic [3:0] kw_len(input logic [4:0] k);
      case (k)
         5'd0:    kw_len = 4'd6;
         5'd1:    kw_len = 4'd2;
         5'd2:    kw_len = 4'd5;
         5'd3:    kw_len = 4'd3;
         5'd4:    kw_len = 4'd1;
         5'd5:    kw_len = 4'd6;
         5'd6:    kw_len = 4'd4;
         5'd7:    kw_len = 4'd4;
         5'd8:    kw_len = 4'd7;
         5'd9:    kw_len = 4'd5;
         5'd10:   kw_len = 4'd7;
         5'd11:   kw_len = 4'd3;
         5'd12:   kw_len = 4'd6;
         5'd13:   kw_len = 4'd5;
         5'd14:   kw_len = 4'd3;
         5'd15:   kw_len = 4'd5;
         5'd16:   kw_len = 4'd9;
         default: kw_len = 4'd0;
      endcase
   endfunction

   function automatic logic digit_char(input logic [7:0] c);
      digit_char = (c >= "0") && (c <= "9");
   endfunction

   function automatic logic is_sym(input logic [7:0] c);
      is_sym = ((c >= "a") && (c <= "z")) || ((c >= "A") && (c <= "Z")) || digit_char(c) ||
               (c == "_") || (c == "?") || (c == "!") || (c == CH_MINUS) ||
               (c == CH_EQ) || (c == CH_LT) || (c == CH_GT);
   endfunction

   // drop keywords whose character at pos differs from c
   function automatic logic [16:0] narrow(input logic [16:0] cands, input logic [11:0] pos,
                                          input logic [7:0] c);
      logic [71:0] txt;
      logic [3:0]  p;
      narrow = cands;
      p = pos[3:0];
      for (int k = 0; k < NUM_KW; k++) begin
         txt = kw_text(5'(k));
         if (!(pos < 12'(kw_len(5'(k)))) || txt[(KW_CHARS - 1 - int'(p)) * 8 +: 8] != c) begin
            narrow[k] = 1'b0;
         end
      end
   endfunction

   function automatic rec_type mk_content(input logic [7:0] c);
      mk_content = '{kind: REC_CONTENT, token_kind: 5'd0, content_byte: c, span_len: 12'd0};
   endfunction

   function automatic rec_type mk_end(input rec_kind_type rk, input logic [4:0] tk,
                                      input logic [11:0] len);
      mk_end = '{kind: rk, token_kind: tk, content_byte: 8'd0, span_len: len};
   endfunction

endpackage

// ----- src/llx_step.sv -----
`timescale 1ns / 1ps
// One lexer step: current lexer state and one input beat to up to three
// result records and the next lexer state. Depends on llx_pkg.
module llx_step #(
   parameter int MAX_TOKEN_LEN = llx_pkg::MAX_TOKEN_LEN_DEF
) (
   input  llx_pkg::lex_state_type cur,
   input  logic [7:0]             char_byte,
   input  logic                   end_of_text,
   output llx_pkg::step_type      step
);

   localparam int LenCap = (MAX_TOKEN_LEN < 4095) ? MAX_TOKEN_LEN : 4095;

   logic [11:0]             bumped;
   logic [4:0]              sym_kind;
   logic                    pend_v;
   llx_pkg::rec_type        pend_rec;
   llx_pkg::rec_type [1:0]  s_recs;
   logic [1:0]              s_n;
   llx_pkg::lex_state_type  s_next;
   logic                    end_v;
   logic                    do_start;

   assign bumped = (cur.run_length < 12'(LenCap)) ? cur.run_length + 12'd1 : cur.run_length;

   always_comb begin
      sym_kind = llx_pkg::TK_SYMBOL;
      for (int k = llx_pkg::NUM_KW - 1; k >= 0; k--) begin
         if (cur.cands[k] && cur.run_length == 12'(llx_pkg::kw_len(5'(k)))) begin
            sym_kind = llx_pkg::TK_KW0 + 5'(k);
         end
      end
   end

   always_comb begin
      pend_v = 1'b1;
      pend_rec = '0;
      case (cur.mode)
         llx_pkg::MODE_NUMBER: begin
            pend_rec = llx_pkg::mk_end(llx_pkg::REC_END, llx_pkg::TK_NUMBER, cur.run_length);
         end
         llx_pkg::MODE_SYMBOL: begin
            pend_rec = llx_pkg::mk_end(llx_pkg::REC_END, sym_kind, cur.run_length);
         end
         llx_pkg::MODE_GT: begin
            pend_rec = llx_pkg::mk_end(llx_pkg::REC_END, llx_pkg::TK_GT, 12'd1);
         end
         llx_pkg::MODE_LT: begin
            pend_rec = llx_pkg::mk_end(llx_pkg::REC_END, llx_pkg::TK_LT, 12'd1);
         end
         default: begin
            pend_v = 1'b0;
         end
      endcase
   end

   // lex a byte from a cleared state
   always_comb begin
      s_recs = '0;
      s_n = 2'd0;
      s_next = llx_pkg::LEX_RESET;
      case (char_byte)
         llx_pkg::CH_SPACE, llx_pkg::CH_LF, llx_pkg::CH_TAB: begin
            s_n = 2'd0;
         end
         llx_pkg::CH_SEMI: begin
            s_next.mode = llx_pkg::MODE_COMMENT;
         end
         llx_pkg::CH_QUOTE: begin
            s_next.mode = llx_pkg::MODE_STRING;
         end
         llx_pkg::CH_LPAREN, llx_pkg::CH_RPAREN, llx_pkg::CH_PLUS, llx_pkg::CH_MINUS,
         llx_pkg::CH_STAR, llx_pkg::CH_SLASH, llx_pkg::CH_EQ: begin
            s_recs[0] = llx_pkg::mk_content(char_byte);
            s_n = 2'd2;
            case (char_byte)
               llx_pkg::CH_LPAREN: begin
                  s_recs[1] = llx_pkg::mk_end(llx_pkg::REC_END, llx_pkg::TK_LPAREN, 12'd1);
               end
               llx_pkg::CH_RPAREN: begin
                  s_recs[1] = llx_pkg::mk_end(llx_pkg::REC_END, llx_pkg::TK_RPAREN, 12'd1);
               end
               llx_pkg::CH_PLUS: begin
                  s_recs[1] = llx_pkg::mk_end(llx_pkg::REC_END, llx_pkg::TK_PLUS, 12'd1);
               end
               llx_pkg::CH_MINUS: begin
                  s_recs[1] = llx_pkg::mk_end(llx_pkg::REC_END, llx_pkg::TK_MINUS, 12'd1);
               end
               llx_pkg::CH_STAR: begin
                  s_recs[1] = llx_pkg::mk_end(llx_pkg::REC_END, llx_pkg::TK_STAR, 12'd1);
               end
               llx_pkg::CH_SLASH: begin
                  s_recs[1] = llx_pkg::mk_end(llx_pkg::REC_END, llx_pkg::TK_SLASH, 12'd1);
               end
               default: begin
                  s_recs[1] = llx_pkg::mk_end(llx_pkg::REC_END, llx_pkg::TK_EQ, 12'd1);
               end
            endcase
         end
         llx_pkg::CH_GT: begin
            s_recs[0] = llx_pkg::mk_content(char_byte);
            s_n = 2'd1;
            s_next.mode = llx_pkg::MODE_GT;
            s_next.run_length = 12'd1;
         end
         llx_pkg::CH_LT: begin
            s_recs[0] = llx_pkg::mk_content(char_byte);
            s_n = 2'd1;
            s_next.mode = llx_pkg::MODE_LT;
            s_next.run_length = 12'd1;
         end
         default: begin
            if (llx_pkg::digit_char(char_byte)) begin
               s_recs[0] = llx_pkg::mk_content(char_byte);
               s_n = 2'd1;
               s_next.mode = llx_pkg::MODE_NUMBER;
               s_next.run_length = 12'd1;
            end else if (llx_pkg::is_sym(char_byte)) begin
               s_recs[0] = llx_pkg::mk_content(char_byte);
               s_n = 2'd1;
               s_next.mode = llx_pkg::MODE_SYMBOL;
               s_next.run_length = 12'd1;
               s_next.cands = llx_pkg::narrow(llx_pkg::ALL_KW, 12'd0, char_byte);
            end
         end
      endcase
   end

   always_comb begin
      step = '0;
      step.next = cur;
      end_v = 1'b0;
      do_start = 1'b0;
      if (end_of_text) begin
         step.next = llx_pkg::LEX_RESET;
         if (cur.mode == llx_pkg::MODE_STRING) begin
            step.recs[0] = llx_pkg::mk_end(llx_pkg::REC_ERROR, llx_pkg::TK_STRING,
                                           cur.run_length);
            step.recs[1] = llx_pkg::mk_end(llx_pkg::REC_EOT, 5'd0, 12'd0);
            step.count = 2'd2;
         end else if (pend_v) begin
            step.recs[0] = pend_rec;
            step.recs[1] = llx_pkg::mk_end(llx_pkg::REC_EOT, 5'd0, 12'd0);
            step.count = 2'd2;
         end else begin
            step.recs[0] = llx_pkg::mk_end(llx_pkg::REC_EOT, 5'd0, 12'd0);
            step.count = 2'd1;
         end
      end else begin
         case (cur.mode)
            llx_pkg::MODE_COMMENT: begin
               if (char_byte == llx_pkg::CH_LF) begin
                  step.next.mode = llx_pkg::MODE_IDLE;
               end
            end
            llx_pkg::MODE_STRING: begin
               step.count = 2'd1;
               if (char_byte == llx_pkg::CH_QUOTE) begin
                  step.recs[0] = llx_pkg::mk_end(llx_pkg::REC_END, llx_pkg::TK_STRING,
                                                 cur.run_length);
                  step.next = llx_pkg::LEX_RESET;
               end else begin
                  step.recs[0] = llx_pkg::mk_content(char_byte);
                  step.next.run_length = bumped;
               end
            end
            llx_pkg::MODE_NUMBER: begin
               if (llx_pkg::digit_char(char_byte)) begin
                  step.recs[0] = llx_pkg::mk_content(char_byte);
                  step.count = 2'd1;
                  step.next.run_length = bumped;
               end else begin
                  end_v = 1'b1;
                  do_start = 1'b1;
               end
            end
            llx_pkg::MODE_SYMBOL: begin
               if (llx_pkg::is_sym(char_byte)) begin
                  step.recs[0] = llx_pkg::mk_content(char_byte);
                  step.count = 2'd1;
                  step.next.cands = llx_pkg::narrow(cur.cands, cur.run_length, char_byte);
                  step.next.run_length = bumped;
               end else begin
                  end_v = 1'b1;
                  do_start = 1'b1;
               end
            end
            llx_pkg::MODE_GT, llx_pkg::MODE_LT: begin
               if (char_byte == llx_pkg::CH_EQ) begin
                  step.recs[0] = llx_pkg::mk_content(char_byte);
                  step.recs[1] = llx_pkg::mk_end(llx_pkg::REC_END,
                     (cur.mode == llx_pkg::MODE_GT) ? llx_pkg::TK_GTE : llx_pkg::TK_LTE,
                     12'd2);
                  step.count = 2'd2;
                  step.next = llx_pkg::LEX_RESET;
               end else begin
                  end_v = 1'b1;
                  do_start = 1'b1;
               end
            end
            default: begin
               do_start = 1'b1;
            end
         endcase
         if (do_start) begin
            step.next = s_next;
            if (end_v) begin
               step.recs[0] = pend_rec;
               step.recs[1] = s_recs[0];
               step.recs[2] = s_recs[1];
               step.count = s_n + 2'd1;
            end else begin
               step.recs[0] = s_recs[0];
               step.recs[1] = s_recs[1];
               step.count = s_n;
            end
         end
      end
   end

endmodule

// ----- src/lisp_lexer_stream_top.sv -----
`timescale 1ns / 1ps
// The first record of a byte is on rsp in the cycle after its req beat is accepted.
// One byte is taken per cycle while each byte yields at most one record and rsp
// is ready; a byte yielding two or three records holds req until the three-entry
// result bank, draining one record per cycle while rsp is ready, is down to its last.
// Reset (synchronous, active high): lexer idle, length zero, all keywords live,
// result bank empty.
module lisp_lexer_stream_top #(
   parameter int MAX_TOKEN_LEN = llx_pkg::MAX_TOKEN_LEN_DEF
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   input  logic [7:0]  req_tdata,   // [7:0] char_byte
   input  logic        req_tlast,   // end_of_text
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   output logic [31:0] rsp_tdata,   // [4:0] token_kind, [12:5] content_byte,
                                    // [24:13] token length, [31:25] zero
   output logic [1:0]  rsp_tuser,   // [1:0] record_kind
   output logic        rsp_tlast    // last_of_run
);

   llx_pkg::lex_state_type state_ff, state_in;
   llx_pkg::rec_type [2:0] bank_ff, bank_in;
   logic [1:0]             left_ff, left_in;
   llx_pkg::step_type      step;
   logic                   req_acc;
   logic                   rsp_acc;

   llx_step #(
      .MAX_TOKEN_LEN(MAX_TOKEN_LEN)
   ) u_step (
      .cur        (state_ff),
      .char_byte  (req_tdata),
      .end_of_text(req_tlast),
      .step       (step)
   );

   assign rsp_tvalid = (left_ff != 2'd0);
   assign rsp_acc    = rsp_tvalid && rsp_tready;
   assign req_tready = (left_ff == 2'd0) || ((left_ff == 2'd1) && rsp_tready);
   assign req_acc    = req_tvalid && req_tready;

   assign rsp_tdata = {7'd0, bank_ff[0].span_len, bank_ff[0].content_byte,
                       bank_ff[0].token_kind};
   assign rsp_tuser = bank_ff[0].kind;
   assign rsp_tlast = (left_ff == 2'd1);

   always_comb begin
      state_in = state_ff;
      bank_in  = bank_ff;
      left_in  = left_ff;
      if (req_acc) begin
         state_in = step.next;
         bank_in  = step.recs;
         left_in  = step.count;
      end else if (rsp_acc) begin
         bank_in[0] = bank_ff[1];
         bank_in[1] = bank_ff[2];
         left_in    = left_ff - 2'd1;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= llx_pkg::LEX_RESET;
         left_ff  <= 2'd0;
      end else begin
         state_ff <= state_in;
         left_ff  <= left_in;
      end
   end

   always_ff @(posedge clock) begin
      bank_ff <= bank_in;
   end

endmodule

// ----- dv/llx_record_monitor.sv -----
`timescale 1ns / 1ps
// Record checker for lisp_lexer_stream_top: watches req and rsp beats, predicts the
// records of every accepted byte and compares them in order, counting failures.
// Depends on llx_pkg for mode, record and token codes.
module llx_record_monitor #(
   parameter int LEN_CAP = (llx_pkg::MAX_TOKEN_LEN_DEF < 4095) ?
                           llx_pkg::MAX_TOKEN_LEN_DEF : 4095
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   input  logic        req_tready,
   input  logic [7:0]  req_tdata,
   input  logic        req_tlast,
   input  logic        rsp_tvalid,
   input  logic        rsp_tready,
   input  logic [31:0] rsp_tdata,
   input  logic [1:0]  rsp_tuser,
   input  logic        rsp_tlast,
   output int          fail_count,
   output int          pending
);

   typedef struct packed {
      llx_pkg::rec_kind_type kind;
      logic [4:0]            token_kind;
      logic [7:0]            content_byte;
      logic [11:0]           span_len;
      logic                  last;
   } lex_record_type;

   string kw_names [llx_pkg::NUM_KW] = '{"lambda", "if", "quote", "nil", "t", "define",
                                         "set!", "loop", "dotimes", "print", "println",
                                         "str", "length", "bool?", "now", "sleep",
                                         "time-diff"};

   llx_pkg::mode_type lex_mode = llx_pkg::MODE_IDLE;
   logic [11:0]       tok_len = '0;
   logic [16:0]       kw_live = llx_pkg::ALL_KW;
   lex_record_type    step_recs [3];
   int                step_n = 0;
   lex_record_type    awaited_records [$];

   function automatic void put(input llx_pkg::rec_kind_type k, input logic [4:0] tk,
                               input logic [7:0] cb, input logic [11:0] len);
      if (step_n < 3) begin
         step_recs[step_n] = '{kind: k, token_kind: tk, content_byte: cb,
                               span_len: len, last: 1'b0};
         step_n++;
      end
   endfunction

   function automatic bit digit_c(input logic [7:0] c);
      return c >= "0" && c <= "9";
   endfunction

   function automatic bit sym_c(input logic [7:0] c);
      logic [7:0] low;
      low = c | 8'h20;
      case (c)
         "_", "?", "!", llx_pkg::CH_MINUS, llx_pkg::CH_EQ, llx_pkg::CH_LT,
         llx_pkg::CH_GT: return 1'b1;
         default: return (c >= "A" && c <= "Z") || (low >= "a" && low <= "z" && c >= "a") ||
                         digit_c(c);
      endcase
   endfunction

   function automatic void clear_tok();
      lex_mode = llx_pkg::MODE_IDLE;
      tok_len = '0;
      kw_live = llx_pkg::ALL_KW;
   endfunction

   function automatic void grow();
      if (tok_len < 12'(LEN_CAP)) tok_len = tok_len + 12'd1;
   endfunction

   function automatic void drop_keywords(input logic [7:0] c);
      string w;
      int    pos;
      pos = int'(tok_len);
      for (int k = 0; k < llx_pkg::NUM_KW; k++) begin
         w = kw_names[k];
         if (kw_live[k] && (pos >= w.len() || w[pos] != c)) kw_live[k] = 1'b0;
      end
   endfunction

   function automatic void close_tok();
      logic [4:0] kind;
      bit         found;
      kind = llx_pkg::TK_SYMBOL;
      found = 1'b0;
      case (lex_mode)
         llx_pkg::MODE_NUMBER: put(llx_pkg::REC_END, llx_pkg::TK_NUMBER, 8'd0, tok_len);
         llx_pkg::MODE_GT:     put(llx_pkg::REC_END, llx_pkg::TK_GT, 8'd0, 12'd1);
         llx_pkg::MODE_LT:     put(llx_pkg::REC_END, llx_pkg::TK_LT, 8'd0, 12'd1);
         llx_pkg::MODE_SYMBOL: begin
            for (int k = 0; k < llx_pkg::NUM_KW; k++) begin
               if (!found && kw_live[k] && kw_names[k].len() == int'(tok_len)) begin
                  kind = llx_pkg::TK_KW0 + 5'(k);
                  found = 1'b1;
               end
            end
            put(llx_pkg::REC_END, kind, 8'd0, tok_len);
         end
         default: ;
      endcase
      clear_tok();
   endfunction

   function automatic void lone(input logic [7:0] c, input logic [4:0] tk);
      put(llx_pkg::REC_CONTENT, 5'd0, c, 12'd0);
      put(llx_pkg::REC_END, tk, 8'd0, 12'd1);
   endfunction

   function automatic void open_tok(input logic [7:0] c);
      clear_tok();
      case (c)
         llx_pkg::CH_SPACE, llx_pkg::CH_LF, llx_pkg::CH_TAB: ;
         llx_pkg::CH_SEMI:   lex_mode = llx_pkg::MODE_COMMENT;
         llx_pkg::CH_LPAREN: lone(c, llx_pkg::TK_LPAREN);
         llx_pkg::CH_RPAREN: lone(c, llx_pkg::TK_RPAREN);
         llx_pkg::CH_PLUS:   lone(c, llx_pkg::TK_PLUS);
         llx_pkg::CH_MINUS:  lone(c, llx_pkg::TK_MINUS);
         llx_pkg::CH_STAR:   lone(c, llx_pkg::TK_STAR);
         llx_pkg::CH_SLASH:  lone(c, llx_pkg::TK_SLASH);
         llx_pkg::CH_EQ:     lone(c, llx_pkg::TK_EQ);
         llx_pkg::CH_QUOTE:  lex_mode = llx_pkg::MODE_STRING;
         llx_pkg::CH_GT, llx_pkg::CH_LT: begin
            put(llx_pkg::REC_CONTENT, 5'd0, c, 12'd0);
            lex_mode = (c == llx_pkg::CH_GT) ? llx_pkg::MODE_GT : llx_pkg::MODE_LT;
            tok_len = 12'd1;
         end
         default: begin
            if (digit_c(c)) begin
               put(llx_pkg::REC_CONTENT, 5'd0, c, 12'd0);
               lex_mode = llx_pkg::MODE_NUMBER;
               tok_len = 12'd1;
            end else if (sym_c(c)) begin
               put(llx_pkg::REC_CONTENT, 5'd0, c, 12'd0);
               lex_mode = llx_pkg::MODE_SYMBOL;
               drop_keywords(c);
               tok_len = 12'd1;
            end
         end
      endcase
   endfunction

   function automatic void lex_byte(input logic [7:0] c, input logic eot);
      step_n = 0;
      if (eot) begin
         if (lex_mode == llx_pkg::MODE_STRING)
            put(llx_pkg::REC_ERROR, llx_pkg::TK_STRING, 8'd0, tok_len);
         else close_tok();
         put(llx_pkg::REC_EOT, 5'd0, 8'd0, 12'd0);
         clear_tok();
      end else begin
         case (lex_mode)
            llx_pkg::MODE_COMMENT: if (c == llx_pkg::CH_LF) lex_mode = llx_pkg::MODE_IDLE;
            llx_pkg::MODE_STRING: begin
               if (c == llx_pkg::CH_QUOTE) begin
                  put(llx_pkg::REC_END, llx_pkg::TK_STRING, 8'd0, tok_len);
                  clear_tok();
               end else begin
                  put(llx_pkg::REC_CONTENT, 5'd0, c, 12'd0);
                  grow();
               end
            end
            llx_pkg::MODE_NUMBER: begin
               if (digit_c(c)) begin
                  put(llx_pkg::REC_CONTENT, 5'd0, c, 12'd0);
                  grow();
               end else begin
                  close_tok();
                  open_tok(c);
               end
            end
            llx_pkg::MODE_SYMBOL: begin
               if (sym_c(c)) begin
                  put(llx_pkg::REC_CONTENT, 5'd0, c, 12'd0);
                  drop_keywords(c);
                  grow();
               end else begin
                  close_tok();
                  open_tok(c);
               end
            end
            llx_pkg::MODE_GT, llx_pkg::MODE_LT: begin
               if (c == llx_pkg::CH_EQ) begin
                  put(llx_pkg::REC_CONTENT, 5'd0, c, 12'd0);
                  put(llx_pkg::REC_END,
                      (lex_mode == llx_pkg::MODE_GT) ? llx_pkg::TK_GTE : llx_pkg::TK_LTE,
                      8'd0, 12'd2);
                  clear_tok();
               end else begin
                  close_tok();
                  open_tok(c);
               end
            end
            default: open_tok(c);
         endcase
      end
      for (int i = 0; i < step_n; i++) begin
         if (i == step_n - 1) step_recs[i].last = 1'b1;
         awaited_records.push_back(step_recs[i]);
      end
   endfunction

   function automatic void check_record();
      lex_record_type got;
      lex_record_type want;
      got = '{kind: llx_pkg::rec_kind_type'(rsp_tuser), token_kind: rsp_tdata[4:0],
              content_byte: rsp_tdata[12:5], span_len: rsp_tdata[24:13], last: rsp_tlast};
      if (awaited_records.size() == 0) begin
         fail_count++;
         if (fail_count <= 10)
            $display("unexpected record: kind %0d token %0d byte %02h len %0d last %0b",
                     got.kind, got.token_kind, got.content_byte, got.span_len, got.last);
      end else begin
         want = awaited_records.pop_front();
         if (got !== want || rsp_tdata[31:25] !== 7'd0) begin
            fail_count++;
            if (fail_count <= 10)
               $display({"record mismatch: expected kind %0d token %0d byte %02h len %0d ",
                         "last %0b, got kind %0d token %0d byte %02h len %0d last %0b pad %02h"},
                        want.kind, want.token_kind, want.content_byte, want.span_len,
                        want.last, got.kind, got.token_kind, got.content_byte,
                        got.span_len, got.last, rsp_tdata[31:25]);
         end
      end
   endfunction

   always @(posedge clock) begin
      if (reset) begin
         clear_tok();
         awaited_records.delete();
      end else begin
         if (rsp_tvalid && rsp_tready) check_record();
         if (req_tvalid && req_tready) lex_byte(req_tdata, req_tlast);
      end
      pending <= awaited_records.size();
   end

endmodule

// ----- dv/tb.sv -----
`timescale 1ns / 1ps
// Testbench top for lisp_lexer_stream_top: drives byte beats and end-of-text beats
// under random idling on both sides and gives the verdict from llx_record_monitor.
// Depends on llx_pkg, lisp_lexer_stream_top and llx_record_monitor.
module tb;

   localparam int LIMIT = 1000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_tvalid = 1'b0;
   logic        req_tready;
   logic [7:0]  req_tdata = 8'd0;
   logic        req_tlast = 1'b0;
   logic        rsp_tvalid;
   logic        rsp_tready = 1'b0;
   logic [31:0] rsp_tdata;
   logic [1:0]  rsp_tuser;
   logic        rsp_tlast;

   int fail_count;
   int pending;
   int cycles = 0;
   int tx_idle_pct = 12;
   int rx_idle_pct = 59;
   int token_bytes = 0;
   int kw_turn = 0;

   string kw_words [llx_pkg::NUM_KW] = '{"lambda", "if", "quote", "nil", "t", "define",
                                         "set!", "loop", "dotimes", "print", "println",
                                         "str", "length", "bool?", "now", "sleep",
                                         "time-diff"};
   string lead_pool = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ_?!";
   string sym_pool = "abcdefghijklmnopqrstuvwxyzABCDEFGHIJKLMNOPQRSTUVWXYZ0123456789_?!-=<>";
   string op_pool = "()+-*/=<>";

   lisp_lexer_stream_top uut (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast)
   );

   llx_record_monitor monitor (
      .clock(clock), .reset(reset),
      .req_tvalid(req_tvalid), .req_tready(req_tready),
      .req_tdata(req_tdata), .req_tlast(req_tlast),
      .rsp_tvalid(rsp_tvalid), .rsp_tready(rsp_tready),
      .rsp_tdata(rsp_tdata), .rsp_tuser(rsp_tuser), .rsp_tlast(rsp_tlast),
      .fail_count(fail_count), .pending(pending)
   );

   always begin
      #6 clock = 1'b1;
      #6 clock = 1'b0;
   end

   always @(posedge clock) begin
      rsp_tready <= ($urandom_range(99) >= rx_idle_pct);
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > LIMIT) begin
         $display("status: fail");
         $finish;
      end
   end

   task automatic push_item(input logic [7:0] c, input logic eot);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_tvalid <= 1'b0;
         @(posedge clock);
      end
      req_tvalid <= 1'b1;
      req_tdata <= c;
      req_tlast <= eot;
      @(posedge clock);
      while (!req_tready) @(posedge clock);
   endtask

   task automatic push_text(input string s);
      for (int i = 0; i < s.len(); i++) push_item(s[i], 1'b0);
   endtask

   task automatic send_token();
      int         pick;
      int         n;
      string      w;
      logic [7:0] ch;
      pick = $urandom_range(99);
      if (pick < 25) begin
         // cycle through keywords, sometimes cut short or extended by one
         w = kw_words[kw_turn % llx_pkg::NUM_KW];
         kw_turn++;
         n = w.len();
         pick = $urandom_range(9);
         if (pick == 0 && n > 1) n--;
         for (int i = 0; i < n; i++) push_item(w[i], 1'b0);
         if (pick == 1) begin
            push_item(sym_pool[$urandom_range(sym_pool.len() - 1)], 1'b0);
            n++;
         end
         token_bytes += n;
      end else if (pick < 40) begin
         n = $urandom_range(1, 8);
         push_item(lead_pool[$urandom_range(lead_pool.len() - 1)], 1'b0);
         for (int i = 1; i < n; i++)
            push_item(sym_pool[$urandom_range(sym_pool.len() - 1)], 1'b0);
         token_bytes += n;
      end else if (pick < 52) begin
         n = $urandom_range(1, 6);
         for (int i = 0; i < n; i++) push_item(8'("0" + $urandom_range(9)), 1'b0);
         token_bytes += n;
      end else if (pick < 64) begin
         n = $urandom_range(0, 12);
         push_item(llx_pkg::CH_QUOTE, 1'b0);
         for (int i = 0; i < n; i++) begin
            ch = 8'($urandom_range(255));
            if (ch == llx_pkg::CH_QUOTE) ch = ch ^ 8'h01;
            push_item(ch, 1'b0);
         end
         // leave some strings open
         if ($urandom_range(7) != 0) push_item(llx_pkg::CH_QUOTE, 1'b0);
         token_bytes += n + 2;
      end else if (pick < 80) begin
         ch = op_pool[$urandom_range(op_pool.len() - 1)];
         push_item(ch, 1'b0);
         token_bytes++;
         if ((ch == llx_pkg::CH_LT || ch == llx_pkg::CH_GT) && $urandom_range(1) == 1) begin
            push_item(llx_pkg::CH_EQ, 1'b0);
            token_bytes++;
         end
      end else if (pick < 88) begin
         n = $urandom_range(0, 10);
         push_item(llx_pkg::CH_SEMI, 1'b0);
         for (int i = 0; i < n; i++) push_item(8'($urandom_range(32, 126)), 1'b0);
         push_item(llx_pkg::CH_LF, 1'b0);
      end else begin
         push_item(8'($urandom_range(255)), 1'b0);
         token_bytes++;
      end
      pick = $urandom_range(19);
      if (pick < 6) push_item(llx_pkg::CH_SPACE, 1'b0);
      else if (pick < 8) push_item(llx_pkg::CH_LF, 1'b0);
      else if (pick == 8) push_item(llx_pkg::CH_TAB, 1'b0);
      else if (pick == 9) begin
         push_item(8'($urandom_range(255)), 1'b1);
         token_bytes++;
      end
   endtask

   initial begin
      repeat (10) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      push_text("(+-*/=)>=<=>1<x 42;z");
      push_item(llx_pkg::CH_LF, 1'b0);
      push_item(8'hFF, 1'b1);
      push_item(llx_pkg::CH_QUOTE, 1'b0);
      push_item(8'h00, 1'b0);
      push_item(8'hFF, 1'b0);
      push_item(8'h00, 1'b1);

      for (int phase = 0; phase < 3; phase++) begin
         tx_idle_pct = (phase == 0) ? 12 : (phase == 1) ? 59 : 0;
         rx_idle_pct = (phase == 0) ? 59 : (phase == 1) ? 12 : 0;
         while (token_bytes < (phase + 1) * 90) send_token();
      end

      push_item(8'h00, 1'b1);
      req_tvalid <= 1'b0;

      @(posedge clock);
      while (pending != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      if (fail_count == 0 && pending == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
